// ----- src/adam_pkg.sv -----
// Shared constants, types and state codes of the Adam update unit.
`default_nettype none

package adam_pkg;

    // Default moment memory depth
    localparam int ELEMENTS_DEF = 1024;

    // Field widths
    localparam int IDX_W   = 10;
    localparam int VAL_W   = 32;
    localparam int LR_W    = 24;
    localparam int BETA_W  = 16;
    localparam int EPS_W   = 24;
    localparam int DECAY_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Moment and power widths
    localparam int M_W   = 32;
    localparam int V_W   = 48;
    localparam int POW_W = 17;

    // Datapath widths
    localparam int ACC_W     = 74;
    localparam int DIV_NUM_W = 72;
    localparam int DIV_DEN_W = 41;
    localparam int DIV_CNT_W = 7;
    localparam int SQ_W      = 64;
    localparam int ROOT_W    = 32;

    // Reset values
    localparam logic [LR_W-1:0]    LR_RST    = 24'd16777;
    localparam logic [BETA_W-1:0]  BETA1_RST = 16'd58982;
    localparam logic [BETA_W-1:0]  BETA2_RST = 16'd65470;
    localparam logic [EPS_W-1:0]   EPS_RST   = 24'd1;
    localparam logic [DECAY_W-1:0] DECAY_RST = 24'd0;
    localparam logic [POW_W-1:0]   ONE_Q16   = 17'd65536;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEARNING_RATE = 3'd0,
        REG_BETA_FIRST    = 3'd1,
        REG_BETA_SECOND   = 3'd2,
        REG_EPSILON       = 3'd3,
        REG_DECAY_FACTOR  = 3'd4
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_POW1,
        ST_POW2,
        ST_DECAY,
        ST_MOM1,
        ST_MOM2,
        ST_SQ1,
        ST_SQ2,
        ST_V1,
        ST_V2,
        ST_V3,
        ST_V4,
        ST_DIVM,
        ST_WAITM,
        ST_WAITV,
        ST_SQRT,
        ST_LR1,
        ST_LR2,
        ST_DIVQ,
        ST_WAITQ
    } state_t;

endpackage

`default_nettype wire

// ----- src/adam_if.sv -----
// Channel interfaces of the Adam update unit: items, results, configuration.
`default_nettype none

interface adam_item_if;
    logic                              valid;
    logic                              ready;
    logic                              step_start;
    logic                              fresh;
    logic [adam_pkg::IDX_W-1:0]        element_index;
    logic signed [adam_pkg::VAL_W-1:0] param_value;
    logic signed [adam_pkg::VAL_W-1:0] gradient;

    modport source (output valid, step_start, fresh, element_index, param_value, gradient,
                    input ready);
    modport sink (input valid, step_start, fresh, element_index, param_value, gradient,
                  output ready);
endinterface

interface adam_result_if;
    logic                              valid;
    logic                              ready;
    logic [adam_pkg::IDX_W-1:0]        out_index;
    logic signed [adam_pkg::VAL_W-1:0] new_value;
    logic                              saturated;

    modport source (output valid, out_index, new_value, saturated, input ready);
    modport sink (input valid, out_index, new_value, saturated, output ready);
endinterface

interface adam_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [adam_pkg::CFG_IDX_W-1:0]     index;
    logic [adam_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/adam_optimizer_update_unit.sv -----
// Adam optimizer element update unit: sequencer, multiply-accumulate and moment memories.
`default_nettype none

// One element is in flight at a time. The unit returns to idle, and can take the next
// item, as the result is loaded into the output register, so a new item is not taken
// until the result of the last one is loaded. The steps in order: multiply-accumulate
// for the beta powers, weight decay, first moment, gradient square and second moment on
// a shared 33x25 multiplier; a state that writes the moments back and starts the shared
// one-bit-per-cycle divider; a 48-bit quotient for the first-moment bias correction, a
// 64-bit one for the second and a square root with a 32-bit result; multiply-accumulate
// for the learning rate; then a state that starts the final division, a 72-bit
// quotient. Moments are read from the memories when the item is taken and written back
// in the state that starts the first division. A finished result waits in an output
// register while the next item is taken; if that register is still full when the next
// result is ready, the unit holds until it frees. Configuration transfers are always
// accepted and should be made only while the unit is idle.

module adam_optimizer_update_unit #(
    parameter int ELEMENTS = adam_pkg::ELEMENTS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    adam_item_if.sink     item_in,
    adam_result_if.source result_out,
    adam_cfg_if.sink      cfg
);

    localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

    // Index reduced modulo the memory depth, one conditional subtract per bit
    function automatic logic [AW-1:0] slot_of(input logic [adam_pkg::IDX_W-1:0] idx);
        logic [31:0] r;
        r = 32'(idx);
        for (int k = adam_pkg::IDX_W - 1; k >= 0; k--)
        begin
            if (r >= (32'(ELEMENTS) << k))
                r = r - (32'(ELEMENTS) << k);
        end
        return AW'(r);
    endfunction

    // Configuration registers
    logic [adam_pkg::LR_W-1:0]    lr_reg;
    logic [adam_pkg::BETA_W-1:0]  b1_reg;
    logic [adam_pkg::BETA_W-1:0]  b2_reg;
    logic [adam_pkg::EPS_W-1:0]   eps_reg;
    logic [adam_pkg::DECAY_W-1:0] decay_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg    <= adam_pkg::LR_RST;
            b1_reg    <= adam_pkg::BETA1_RST;
            b2_reg    <= adam_pkg::BETA2_RST;
            eps_reg   <= adam_pkg::EPS_RST;
            decay_reg <= adam_pkg::DECAY_RST;
        end
        else if (cfg.valid)
        begin
            unique case (adam_pkg::cfg_reg_t'(cfg.index))
                adam_pkg::REG_LEARNING_RATE: lr_reg    <= cfg.data;
                adam_pkg::REG_BETA_FIRST:    b1_reg    <= cfg.data[adam_pkg::BETA_W-1:0];
                adam_pkg::REG_BETA_SECOND:   b2_reg    <= cfg.data[adam_pkg::BETA_W-1:0];
                adam_pkg::REG_EPSILON:       eps_reg   <= cfg.data;
                adam_pkg::REG_DECAY_FACTOR:  decay_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // State and handshake
    adam_pkg::state_t state_reg, state_next;
    logic             out_valid_reg;
    logic             out_free;
    logic             in_xfer;
    logic             out_load;

    assign item_in.ready = (state_reg == adam_pkg::ST_IDLE);
    assign in_xfer       = item_in.valid && item_in.ready;
    assign out_free      = !out_valid_reg || result_out.ready;

    // Latched item
    logic                               start_reg;
    logic                               fresh_reg;
    logic [adam_pkg::IDX_W-1:0]         idx_reg;
    logic [AW-1:0]                      slot_reg;
    logic signed [adam_pkg::VAL_W-1:0]  p_reg;
    logic signed [adam_pkg::VAL_W-1:0]  g_reg;

    // Working values
    logic [adam_pkg::POW_W-1:0]         b1pow_reg;
    logic [adam_pkg::POW_W-1:0]         b2pow_reg;
    logic signed [adam_pkg::VAL_W-1:0]  ge_reg;
    logic signed [adam_pkg::M_W-1:0]    m1_reg;
    logic [adam_pkg::V_W-1:0]           g2_reg;
    logic [adam_pkg::V_W-1:0]           v1_reg;
    logic [adam_pkg::V_W-1:0]           mmag_reg;
    logic [adam_pkg::DIV_DEN_W-1:0]     den_reg;
    logic signed [adam_pkg::ACC_W-1:0]  acc_reg;

    // Memory
    logic [adam_pkg::M_W-1:0] rd_m;
    logic [adam_pkg::V_W-1:0] rd_v;
    logic                     mem_wr;
    logic [adam_pkg::V_W-1:0] v1_new;

    assign v1_new = acc_reg[63:16];

    adam_mem #(
        .ELEMENTS (ELEMENTS),
        .AW       (AW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (in_xfer),
        .rd_addr (slot_of(item_in.element_index)),
        .wr_en   (mem_wr),
        .wr_addr (slot_reg),
        .wr_m    (m1_reg),
        .wr_v    (v1_new),
        .rd_m    (rd_m),
        .rd_v    (rd_v)
    );

    // Divider and square root
    logic                               div_start;
    logic [adam_pkg::DIV_NUM_W-1:0]     div_num;
    logic [adam_pkg::DIV_DEN_W-1:0]     div_den;
    logic [adam_pkg::DIV_CNT_W-1:0]     div_nbits;
    logic                               div_busy;
    logic [adam_pkg::DIV_NUM_W-1:0]     div_quo;
    logic                               sq_start;
    logic                               sq_busy;
    logic [adam_pkg::ROOT_W-1:0]        sq_root;

    adam_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .nbits (div_nbits),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    adam_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (div_quo[adam_pkg::SQ_W-1:0]),
        .busy     (sq_busy),
        .root     (sq_root)
    );

    // Derived operands
    logic signed [adam_pkg::M_W-1:0]    m0;
    logic [adam_pkg::V_W-1:0]           v0;
    logic [adam_pkg::VAL_W-1:0]         ge_abs;
    logic [adam_pkg::M_W-1:0]           m1_abs;
    logic [adam_pkg::POW_W-1:0]         bc1;
    logic [adam_pkg::POW_W-1:0]         bc2;
    logic [adam_pkg::POW_W-1:0]         omb1;
    logic [adam_pkg::POW_W-1:0]         omb2;

    assign m0     = fresh_reg ? '0 : $signed(rd_m);
    assign v0     = fresh_reg ? '0 : rd_v;
    assign ge_abs = ge_reg[31] ? 32'(-ge_reg) : 32'(ge_reg);
    assign m1_abs = m1_reg[31] ? 32'(-m1_reg) : 32'(m1_reg);
    assign bc1    = b1pow_reg[16] ? 17'd1 : adam_pkg::ONE_Q16 - b1pow_reg;
    assign bc2    = b2pow_reg[16] ? 17'd1 : adam_pkg::ONE_Q16 - b2pow_reg;
    assign omb1   = adam_pkg::ONE_Q16 - {1'b0, b1_reg};
    assign omb2   = adam_pkg::ONE_Q16 - {1'b0, b2_reg};

    // Multiply-accumulate
    logic signed [32:0]                 mac_a;
    logic signed [24:0]                 mac_b;
    logic                               mac_clr;
    logic                               mac_sh;
    logic                               mac_en;
    logic signed [57:0]                 mac_prod;
    logic signed [adam_pkg::ACC_W-1:0]  prod_ext;
    logic signed [adam_pkg::ACC_W-1:0]  acc_next;

    assign mac_prod = mac_a * mac_b;
    assign prod_ext = {{(adam_pkg::ACC_W - 58){mac_prod[57]}}, mac_prod};
    assign acc_next = (mac_clr ? '0 : acc_reg) + (mac_sh ? (prod_ext <<< 24) : prod_ext);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            adam_pkg::ST_IDLE:  if (in_xfer) state_next = adam_pkg::ST_POW1;
            adam_pkg::ST_POW1:  state_next = adam_pkg::ST_POW2;
            adam_pkg::ST_POW2:  state_next = adam_pkg::ST_DECAY;
            adam_pkg::ST_DECAY: state_next = adam_pkg::ST_MOM1;
            adam_pkg::ST_MOM1:  state_next = adam_pkg::ST_MOM2;
            adam_pkg::ST_MOM2:  state_next = adam_pkg::ST_SQ1;
            adam_pkg::ST_SQ1:   state_next = adam_pkg::ST_SQ2;
            adam_pkg::ST_SQ2:   state_next = adam_pkg::ST_V1;
            adam_pkg::ST_V1:    state_next = adam_pkg::ST_V2;
            adam_pkg::ST_V2:    state_next = adam_pkg::ST_V3;
            adam_pkg::ST_V3:    state_next = adam_pkg::ST_V4;
            adam_pkg::ST_V4:    state_next = adam_pkg::ST_DIVM;
            adam_pkg::ST_DIVM:  state_next = adam_pkg::ST_WAITM;
            adam_pkg::ST_WAITM: if (!div_busy) state_next = adam_pkg::ST_WAITV;
            adam_pkg::ST_WAITV: if (!div_busy) state_next = adam_pkg::ST_SQRT;
            adam_pkg::ST_SQRT:  if (!sq_busy) state_next = adam_pkg::ST_LR1;
            adam_pkg::ST_LR1:   state_next = adam_pkg::ST_LR2;
            adam_pkg::ST_LR2:   state_next = adam_pkg::ST_DIVQ;
            adam_pkg::ST_DIVQ:  state_next = adam_pkg::ST_WAITQ;
            adam_pkg::ST_WAITQ: if (!div_busy && out_free) state_next = adam_pkg::ST_IDLE;
            default:            state_next = adam_pkg::ST_IDLE;
        endcase
    end

    // Datapath controls
    always_comb
    begin
        mac_a     = '0;
        mac_b     = '0;
        mac_clr   = 1'b0;
        mac_sh    = 1'b0;
        mac_en    = 1'b0;
        mem_wr    = 1'b0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        div_nbits = '0;
        sq_start  = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            adam_pkg::ST_POW1:
            begin
                mac_en = 1'b1; mac_clr = 1'b1;
                mac_a = 33'(b1pow_reg); mac_b = 25'(b1_reg);
            end
            adam_pkg::ST_POW2:
            begin
                mac_en = 1'b1; mac_clr = 1'b1;
                mac_a = 33'(b2pow_reg); mac_b = 25'(b2_reg);
            end
            adam_pkg::ST_DECAY:
            begin
                mac_en = 1'b1; mac_clr = 1'b1;
                mac_a = 33'(p_reg); mac_b = 25'(decay_reg);
            end
            adam_pkg::ST_MOM1:
            begin
                mac_en = 1'b1; mac_clr = 1'b1;
                mac_a = 33'(m0); mac_b = 25'(b1_reg);
            end
            adam_pkg::ST_MOM2:
            begin
                mac_en = 1'b1;
                mac_a = 33'(ge_reg); mac_b = 25'(omb1);
            end
            adam_pkg::ST_SQ1:
            begin
                mac_en = 1'b1; mac_clr = 1'b1;
                mac_a = 33'(ge_abs); mac_b = 25'(ge_abs[23:0]);
            end
            adam_pkg::ST_SQ2:
            begin
                mac_en = 1'b1; mac_sh = 1'b1;
                mac_a = 33'(ge_abs); mac_b = 25'(ge_abs[31:24]);
            end
            adam_pkg::ST_V1:
            begin
                mac_en = 1'b1; mac_clr = 1'b1;
                mac_a = 33'(v0[23:0]); mac_b = 25'(b2_reg);
            end
            adam_pkg::ST_V2:
            begin
                mac_en = 1'b1; mac_sh = 1'b1;
                mac_a = 33'(v0[47:24]); mac_b = 25'(b2_reg);
            end
            adam_pkg::ST_V3:
            begin
                mac_en = 1'b1;
                mac_a = 33'(g2_reg[23:0]); mac_b = 25'(omb2);
            end
            adam_pkg::ST_V4:
            begin
                mac_en = 1'b1; mac_sh = 1'b1;
                mac_a = 33'(g2_reg[47:24]); mac_b = 25'(omb2);
            end
            adam_pkg::ST_DIVM:
            begin
                mem_wr    = 1'b1;
                div_start = 1'b1;
                div_num   = {m1_abs, 40'd0};
                div_den   = 41'(bc1);
                div_nbits = 7'd48;
            end
            adam_pkg::ST_WAITM:
            begin
                if (!div_busy)
                begin
                    div_start = 1'b1;
                    div_num   = {v1_reg, 24'd0};
                    div_den   = 41'(bc2);
                    div_nbits = 7'd64;
                end
            end
            adam_pkg::ST_WAITV:
            begin
                sq_start = !div_busy;
            end
            adam_pkg::ST_LR1:
            begin
                mac_en = 1'b1; mac_clr = 1'b1;
                mac_a = 33'(mmag_reg[23:0]); mac_b = 25'(lr_reg);
            end
            adam_pkg::ST_LR2:
            begin
                mac_en = 1'b1; mac_sh = 1'b1;
                mac_a = 33'(mmag_reg[47:24]); mac_b = 25'(lr_reg);
            end
            adam_pkg::ST_DIVQ:
            begin
                div_start = 1'b1;
                div_num   = acc_reg[71:0];
                div_den   = den_reg;
                div_nbits = 7'd72;
            end
            adam_pkg::ST_WAITQ:
            begin
                out_load = !div_busy && out_free;
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= adam_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            b1pow_reg     <= adam_pkg::ONE_Q16;
            b2pow_reg     <= adam_pkg::ONE_Q16;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result_out.ready)
                out_valid_reg <= 1'b0;
            if (state_reg == adam_pkg::ST_POW2 && start_reg)
                b1pow_reg <= acc_reg[32:16];
            if (state_reg == adam_pkg::ST_DECAY && start_reg)
                b2pow_reg <= acc_reg[32:16];
        end
    end

    // Result of the final quotient
    logic [39:0]         q_lo;
    logic                q_big;
    logic signed [41:0]  res_full;
    logic signed [31:0]  res_val;
    logic                res_sat;

    always_comb
    begin
        q_lo     = div_quo[39:0];
        q_big    = |div_quo[71:40];
        res_full = m1_reg[31] ? (42'(p_reg) + $signed({2'b00, q_lo}))
                              : (42'(p_reg) - $signed({2'b00, q_lo}));
        res_sat  = 1'b1;
        priority if (q_big)
            res_val = m1_reg[31] ? 32'sh7FFFFFFF : 32'sh80000000;
        else if (res_full > 42'sd2147483647)
            res_val = 32'sh7FFFFFFF;
        else if (res_full < -42'sd2147483648)
            res_val = 32'sh80000000;
        else
        begin
            res_val = res_full[31:0];
            res_sat = 1'b0;
        end
    end

    // Weight-decayed gradient, saturated, and the denominator from the root and epsilon
    logic signed [40:0] ge_full;
    logic signed [31:0] ge_sat;
    logic [40:0]        den_full;

    always_comb
    begin
        ge_full = 41'(g_reg) + acc_reg[56:16];
        if (ge_full > 41'sd2147483647)
            ge_sat = 32'sh7FFFFFFF;
        else if (ge_full < -41'sd2147483648)
            ge_sat = 32'sh80000000;
        else
            ge_sat = ge_full[31:0];
        den_full = {1'b0, sq_root, 8'd0} + 41'(eps_reg);
    end

    // Payload registers
    logic [adam_pkg::IDX_W-1:0]         out_idx_reg;
    logic signed [adam_pkg::VAL_W-1:0]  out_val_reg;
    logic                               out_sat_reg;

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            start_reg <= item_in.step_start;
            fresh_reg <= item_in.fresh;
            idx_reg   <= item_in.element_index;
            slot_reg  <= slot_of(item_in.element_index);
            p_reg     <= item_in.param_value;
            g_reg     <= item_in.gradient;
        end
        if (mac_en)
            acc_reg <= acc_next;
        if (state_reg == adam_pkg::ST_MOM1)
            ge_reg <= ge_sat;
        if (state_reg == adam_pkg::ST_SQ1)
            m1_reg <= acc_reg[47:16];
        if (state_reg == adam_pkg::ST_V1)
            g2_reg <= (|acc_reg[73:48]) ? '1 : acc_reg[47:0];
        if (state_reg == adam_pkg::ST_DIVM)
            v1_reg <= v1_new;
        if (state_reg == adam_pkg::ST_WAITM && !div_busy)
            mmag_reg <= div_quo[47:0];
        if (state_reg == adam_pkg::ST_SQRT && !sq_busy)
            den_reg <= (den_full == '0) ? 41'd1 : den_full;
        if (out_load)
        begin
            out_idx_reg <= idx_reg;
            out_val_reg <= res_val;
            out_sat_reg <= res_sat;
        end
    end

    assign result_out.valid     = out_valid_reg;
    assign result_out.out_index = out_idx_reg;
    assign result_out.new_value = out_val_reg;
    assign result_out.saturated = out_sat_reg;

endmodule

`default_nettype wire

// ----- src/adam_mem.sv -----
// First and second moment memories, one write and one registered read port.
`default_nettype none

module adam_mem #(
    parameter int ELEMENTS = adam_pkg::ELEMENTS_DEF,
    parameter int AW       = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1
) (
    input  wire logic                      clk,
    input  wire logic                      rd_en,
    input  wire logic [AW-1:0]             rd_addr,
    input  wire logic                      wr_en,
    input  wire logic [AW-1:0]             wr_addr,
    input  wire logic [adam_pkg::M_W-1:0]  wr_m,
    input  wire logic [adam_pkg::V_W-1:0]  wr_v,
    output logic      [adam_pkg::M_W-1:0]  rd_m,
    output logic      [adam_pkg::V_W-1:0]  rd_v
);

    logic [adam_pkg::M_W-1:0] mem_m [ELEMENTS];
    logic [adam_pkg::V_W-1:0] mem_v [ELEMENTS];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_m[wr_addr] <= wr_m;
            mem_v[wr_addr] <= wr_v;
        end
    end

    // Registered read, holds between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_m <= mem_m[rd_addr];
            rd_v <= mem_v[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/adam_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module adam_div (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [adam_pkg::DIV_NUM_W-1:0]     num,   // left-justified
    input  wire logic [adam_pkg::DIV_DEN_W-1:0]     den,
    input  wire logic [adam_pkg::DIV_CNT_W-1:0]     nbits,
    output logic                                    busy,
    output logic      [adam_pkg::DIV_NUM_W-1:0]     quo
);

    logic [adam_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [adam_pkg::DIV_NUM_W-1:0] num_reg, num_next;
    logic [adam_pkg::DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [adam_pkg::DIV_DEN_W-1:0] den_reg, den_next;
    logic [adam_pkg::DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [adam_pkg::DIV_DEN_W:0]   rem_sh;
    logic                           fits;

    // One trial subtraction per cycle
    always_comb
    begin
        rem_sh   = {rem_reg, num_reg[adam_pkg::DIV_NUM_W-1]};
        fits     = (rem_sh >= {1'b0, den_reg});
        cnt_next = cnt_reg;
        num_next = num_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        if (start)
        begin
            cnt_next = nbits;
            num_next = num;
            quo_next = '0;
            den_next = den;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            num_next = {num_reg[adam_pkg::DIV_NUM_W-2:0], 1'b0};
            quo_next = {quo_reg[adam_pkg::DIV_NUM_W-2:0], fits};
            rem_next = fits ? adam_pkg::DIV_DEN_W'(rem_sh - {1'b0, den_reg})
                            : adam_pkg::DIV_DEN_W'(rem_sh);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign busy = (cnt_reg != '0);
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// ----- src/adam_sqrt.sv -----
// Integer square root, two radicand bits per cycle.
`default_nettype none

module adam_sqrt (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [adam_pkg::SQ_W-1:0]     radicand,
    output logic                               busy,
    output logic      [adam_pkg::ROOT_W-1:0]   root
);

    logic [adam_pkg::SQ_W-1:0] x_reg, x_next;
    logic [adam_pkg::SQ_W-1:0] res_reg, res_next;
    logic [adam_pkg::SQ_W-1:0] bit_reg, bit_next;
    logic [adam_pkg::SQ_W-1:0] trial;

    // Digit-by-digit step
    always_comb
    begin
        trial    = res_reg + bit_reg;
        x_next   = x_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        if (start)
        begin
            x_next   = radicand;
            res_next = '0;
            bit_next = adam_pkg::SQ_W'(1) << (adam_pkg::SQ_W - 2);
        end
        else if (bit_reg != '0)
        begin
            if (x_reg >= trial)
            begin
                x_next   = x_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bit_reg <= '0;
        else
            bit_reg <= bit_next;
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        res_reg <= res_next;
    end

    assign busy = (bit_reg != '0);
    assign root = res_reg[adam_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

// ----- dv/adam_update_checker.sv -----
// Checker for the Adam update unit: watches the channels, predicts each update and compares.
module adam_update_checker
    import adam_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    adam_item_if   item_in,
    adam_result_if result_out,
    adam_cfg_if    cfg,
    output int     fail_count,
    output int     pending_updates
);

    typedef struct packed {
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
        logic                    clamped;
    } update_t;

    // Shadow registers and state
    logic [LR_W-1:0]    step_size;
    logic [BETA_W-1:0]  decay1;
    logic [BETA_W-1:0]  decay2;
    logic [EPS_W-1:0]   stabilizer;
    logic [DECAY_W-1:0] wd_coef;
    logic [POW_W-1:0]   decay1_pow;
    logic [POW_W-1:0]   decay2_pow;
    logic signed [M_W-1:0] mean_mem [1024];
    logic [V_W-1:0]        sqmean_mem [1024];

    update_t expected_updates[$];

    assign pending_updates = expected_updates.size();

    // Integer square root, rounded down
    function automatic logic [ROOT_W-1:0] floor_root(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r[ROOT_W-1:0];
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Predict one element update and advance the shadow state
    task automatic predict_update(logic start, logic fresh, logic [IDX_W-1:0] idx,
                                  logic signed [VAL_W-1:0] pval,
                                  logic signed [VAL_W-1:0] grad);
        longint ge, m0, m1, res;
        logic [127:0] v0, v1, g2, bc1, bc2, mmag, vhat, den, q;
        logic neg;
        update_t u;
        if (start)
        begin
            decay1_pow = POW_W'(({15'd0, decay1_pow} * decay1) >> 16);
            decay2_pow = POW_W'(({15'd0, decay2_pow} * decay2) >> 16);
        end
        ge = longint'(grad) + ((longint'(wd_coef) * longint'(pval)) >>> 16);
        if (ge > 64'sd2147483647) ge = 64'sd2147483647;
        if (ge < -64'sd2147483648) ge = -64'sd2147483648;
        m0 = fresh ? 0 : longint'(mean_mem[idx]);
        v0 = fresh ? 0 : 128'(sqmean_mem[idx]);
        m1 = (longint'(decay1) * m0 + (65536 - longint'(decay1)) * ge) >>> 16;
        g2 = 128'(ge * ge);
        if (g2 > 128'hFFFF_FFFF_FFFF) g2 = 128'hFFFF_FFFF_FFFF;
        v1 = (128'(decay2) * v0 + (128'd65536 - decay2) * g2) >> 16;
        mean_mem[idx]   = m1[M_W-1:0];
        sqmean_mem[idx] = v1[V_W-1:0];
        bc1 = (decay1_pow >= ONE_Q16) ? 1 : 128'd65536 - decay1_pow;
        bc2 = (decay2_pow >= ONE_Q16) ? 1 : 128'd65536 - decay2_pow;
        neg = m1 < 0;
        mmag = (128'(neg ? -m1 : m1) << 16) / bc1;
        vhat = (v1 << 16) / bc2;
        den = 128'(floor_root(vhat[63:0])) * 256 + stabilizer;
        if (den == 0) den = 1;
        q = (128'(step_size) * mmag) / den;
        u.index = idx;
        u.clamped = 1'b0;
        // Quotient beyond 40 bits is clamped directly
        if (q >= 128'h100_0000_0000)
        begin
            res = neg ? 64'sd2147483647 : -64'sd2147483648;
            u.clamped = 1'b1;
        end
        else
        begin
            res = neg ? longint'(pval) + longint'(q[39:0])
                      : longint'(pval) - longint'(q[39:0]);
            if (res > 64'sd2147483647)
            begin
                res = 64'sd2147483647;
                u.clamped = 1'b1;
            end
            else if (res < -64'sd2147483648)
            begin
                res = -64'sd2147483648;
                u.clamped = 1'b1;
            end
        end
        u.value = res[VAL_W-1:0];
        expected_updates.insert(expected_updates.size(), u);
    endtask

    // Watch all channels at each edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size  = LR_RST;
            decay1     = BETA1_RST;
            decay2     = BETA2_RST;
            stabilizer = EPS_RST;
            wd_coef    = DECAY_RST;
            decay1_pow = ONE_Q16;
            decay2_pow = ONE_Q16;
            expected_updates.delete();
        end
        else
        begin
            update_t exp_u;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_reg_t'(cfg.index))
                    REG_LEARNING_RATE: step_size  = cfg.data;
                    REG_BETA_FIRST:    decay1     = cfg.data[BETA_W-1:0];
                    REG_BETA_SECOND:   decay2     = cfg.data[BETA_W-1:0];
                    REG_EPSILON:       stabilizer = cfg.data;
                    REG_DECAY_FACTOR:  wd_coef    = cfg.data;
                    default: ;
                endcase
            end
            if (item_in.valid && item_in.ready)
                predict_update(item_in.step_start, item_in.fresh, item_in.element_index,
                               item_in.param_value, item_in.gradient);
            if (result_out.valid && result_out.ready)
            begin
                if (expected_updates.size() == 0)
                    report("unexpected result, index", 64'(result_out.out_index), 64'd0);
                else
                begin
                    exp_u = expected_updates.pop_front();
                    if (result_out.out_index != exp_u.index)
                        report("out_index", 64'(result_out.out_index), 64'(exp_u.index));
                    if (result_out.new_value != exp_u.value)
                        report("new_value", 64'(unsigned'(result_out.new_value)),
                               64'(unsigned'(exp_u.value)));
                    if (result_out.saturated != exp_u.clamped)
                        report("saturated", 64'(result_out.saturated), 64'(exp_u.clamped));
                end
            end
        end
    end

endmodule

// ----- dv/testbench.sv -----
// Top of the Adam update unit bench: clock, reset, stimulus, stalls and verdict.
module testbench;
    import adam_pkg::*;

    localparam int DRAIN_CYCLES = 300;
    localparam int STALL_LIMIT  = 5000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_updates;
    int   idle_cycles;
    int   items_sent;
    bit   written [1024];

    adam_item_if   item_ch ();
    adam_result_if result_ch ();
    adam_cfg_if    cfg_ch ();

    adam_optimizer_update_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_ch),
        .result_out (result_ch),
        .cfg        (cfg_ch)
    );

    adam_update_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_in         (item_ch),
        .result_out      (result_ch),
        .cfg             (cfg_ch),
        .fail_count      (fail_count),
        .pending_updates (pending_updates)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap length: mostly short, now and then long
    function automatic int gap_len();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
        return $urandom_range(1, 4);
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_registers(logic [23:0] lr, logic [15:0] b1, logic [15:0] b2,
                                 logic [23:0] eps, logic [23:0] wd);
        write_reg(REG_LEARNING_RATE, lr);
        write_reg(REG_BETA_FIRST, {8'd0, b1});
        write_reg(REG_BETA_SECOND, {8'd0, b2});
        write_reg(REG_EPSILON, eps);
        write_reg(REG_DECAY_FACTOR, wd);
    endtask

    // Stop offering, wait until every update is back, then let the unit settle
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_updates != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_item(logic start, logic fresh, logic [IDX_W-1:0] idx,
                             logic signed [VAL_W-1:0] pval, logic signed [VAL_W-1:0] grad);
        int gap;
        // An entry never written must start fresh
        if (!written[idx]) fresh = 1'b1;
        written[idx] = 1'b1;
        item_ch.valid         <= 1'b1;
        item_ch.step_start    <= start;
        item_ch.fresh         <= fresh;
        item_ch.element_index <= idx;
        item_ch.param_value   <= pval;
        item_ch.gradient      <= grad;
        do @(posedge clk); while (!item_ch.ready);
        items_sent++;
        gap = gap_len();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic signed [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 131072)) - 65536;
            2: return $signed($urandom_range(0, 2097152)) - 1048576;
            default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
    endfunction

    // One optimizer step over count random elements; later items may start a further step
    task automatic random_step(int count);
        logic [IDX_W-1:0] idx;
        for (int k = 0; k < count; k++)
        begin
            idx = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, 15));
            send_item(k == 0 ? 1'b1 : ($urandom_range(0, 15) == 0), $urandom_range(0, 7) == 0,
                      idx, rand_value(), rand_value());
        end
    endtask

    // Stimulus
    initial
    begin
        item_ch.valid         <= 1'b0;
        item_ch.step_start    <= 1'b0;
        item_ch.fresh         <= 1'b0;
        item_ch.element_index <= '0;
        item_ch.param_value   <= '0;
        item_ch.gradient      <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= REG_LEARNING_RATE;
        cfg_ch.data           <= '0;
        items_sent = 0;
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: no step yet, extremes, reuse, wide index
        send_item(1'b0, 1'b1, 10'd0, 32'sd65536, 32'sd65536);
        send_item(1'b0, 1'b0, 10'd0, 32'sd65536, -32'sd65536);
        send_item(1'b1, 1'b1, 10'd1023, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_item(1'b0, 1'b1, 10'd512, 32'sh8000_0000, 32'sh8000_0000);
        send_item(1'b0, 1'b0, 10'd1023, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_item(1'b1, 1'b1, 10'd1, 32'sd0, 32'sd0);
        send_item(1'b0, 1'b0, 10'd1, 32'sd0, 32'sd1);
        send_item(1'b1, 1'b0, 10'd512, 32'sh7FFF_FFFF, -32'sd1);
        drain();

        // Large step, weight decay at maximum, tiny epsilon
        set_registers(24'hFF_FFFF, 16'd0, 16'd0, 24'd1, 24'hFF_FFFF);
        send_item(1'b1, 1'b1, 10'd2, 32'sh7FFF_FFFF, 32'sd0);
        send_item(1'b0, 1'b1, 10'd3, 32'sh8000_0000, 32'sd0);
        send_item(1'b0, 1'b1, 10'd4, 32'sd0, 32'sd0);
        send_item(1'b1, 1'b0, 10'd2, 32'sd12345, -32'sd99999);
        random_step(150);
        drain();

        // Decays at maximum, huge epsilon, smallest step
        set_registers(24'd1, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 24'd0);
        send_item(1'b1, 1'b1, 10'd5, 32'sd65536, 32'sh7FFF_FFFF);
        random_step(150);
        drain();

        // Default-like settings with modest decay
        set_registers(24'd16777, 16'd58982, 16'd65470, 24'd1, 24'd655);
        for (int s = 0; s < 10; s++)
            random_step($urandom_range(5, 25));
        drain();

        // Random settings
        for (int p = 0; p < 3; p++)
        begin
            set_registers(24'($urandom_range(1, 24'hFF_FFFF)), 16'($urandom), 16'($urandom),
                          24'($urandom_range(1, 24'hFF_FFFF)), 24'($urandom));
            random_step(80);
            drain();
        end

        // Back to reset values
        set_registers(LR_RST, BETA1_RST, BETA2_RST, EPS_RST, DECAY_RST);
        random_step(60);
        drain();

        if (fail_count == 0 && pending_updates == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Result side: random stalls, quiet stretches, one long hold-off
    initial
    begin
        int stall_left;
        int mode_left;
        bit quiet;
        bit held;
        result_ch.ready <= 1'b0;
        stall_left = 0;
        mode_left = 0;
        quiet = 0;
        held = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && items_sent >= 40)
            begin
                held = 1;
                stall_left = 600;
            end
            if (mode_left == 0)
            begin
                quiet = $urandom_range(0, 3) == 0;
                mode_left = $urandom_range(100, 400);
            end
            mode_left--;
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0)
                    stall_left = gap_len();
            end
        end
    end

    // Watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
